// ===== design/winograd_f4x3_tile_transform_assert.svh =====
// ---------------------------------------------------------------------------
// Winograd tile transform assertion macros
// Shared concurrent assertion forms. Each use expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef WINOGRAD_F4X3_TILE_TRANSFORM_ASSERT_SVH
`define WINOGRAD_F4X3_TILE_TRANSFORM_ASSERT_SVH

// The property must hold at every rising edge outside reset.
`define WFT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// The expression must never be true outside reset.
`define WFT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/wft_pkg.sv =====
// ---------------------------------------------------------------------------
// Winograd tile transform package
// Widths, fixed-point constants, controller/datapath interface types and the
// small-constant matrix row function of the F(4x4,3x3) output transform.
// ---------------------------------------------------------------------------
package wft_pkg;

	// Plane coordinates and configuration registers.
	localparam int DIM_BITS = 12;
	localparam int REG_W    = DIM_BITS + 1;
	localparam int TILE_W   = DIM_BITS - 2;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'd1;
	localparam logic [REG_W-1:0]     REG_RESET      = REG_W'(4096);

	// Tile geometry.
	localparam int ROWS     = 4;
	localparam int COLS     = 4;
	localparam int ORES     = 6;
	localparam int ROW_W    = 2;
	localparam int OROW_W   = 3;
	localparam logic [ROW_W-1:0]  LAST_IN_ROW  = 2'd3;
	localparam logic [OROW_W-1:0] LAST_OUT_ROW = 3'd5;

	// Datapath widths: samples, first-pass sums, second-pass sums.
	localparam int SAMPLE_W = 16;
	localparam int T_W      = 21;
	localparam int P_W      = 26;
	localparam int ACC_W    = 28;
	localparam int RES_W    = 24;

	// Scaling r = floor((4P + 4) / 9). A bias that is a multiple of nine keeps
	// the dividend positive; the division is a multiply by a reciprocal.
	localparam int U_W         = 28;
	localparam int DIVISOR     = 9;
	localparam int BIAS_EXP    = 24;
	localparam int RND_OFS     = 4;
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 29;
	localparam int PROD_W      = U_W + RECIP_W;
	localparam int Q_W         = PROD_W - RECIP_SHIFT;
	localparam logic [U_W-1:0]     DIV_BIAS = U_W'(DIVISOR * (2 ** BIAS_EXP));
	localparam logic [RECIP_W-1:0] RECIP    =
		RECIP_W'(((64'd1 << RECIP_SHIFT) / DIVISOR) + 64'd1);
	localparam int RES_MAX = 8388607;
	localparam int RES_MIN = -8388608;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              wr_en;
		logic [ROW_W-1:0]  wr_row;
		logic              issue;
		logic [OROW_W-1:0] issue_row;
	} wft_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic adv;
	} wft_stat_t;

	// One row of the integer matrix M (A = M / 24) applied to four values.
	function automatic logic signed [ACC_W-1:0] wft_lin(
		input logic [OROW_W-1:0]      sel,
		input logic signed [ACC_W-1:0] a0,
		input logic signed [ACC_W-1:0] a1,
		input logic signed [ACC_W-1:0] a2,
		input logic signed [ACC_W-1:0] a3
	);
		logic signed [ACC_W-1:0] res;
		case (sel)
			3'd0: res = (a0 <<< 2) + (a0 <<< 1);
			3'd1: res = -((a0 + a1 + a2 + a3) <<< 2);
			3'd2: res = (a1 - a0 + a3 - a2) <<< 2;
			3'd3: res = a0 + (a1 <<< 1) + (a2 <<< 2) + (a3 <<< 3);
			3'd4: res = a0 - (a1 <<< 1) + (a2 <<< 2) - (a3 <<< 3);
			3'd5: res = (a3 <<< 4) + (a3 <<< 3);
			default: res = '0;
		endcase
		return res;
	endfunction

endpackage

// ===== design/wft_ctrl.sv =====
// ---------------------------------------------------------------------------
// Winograd tile transform controller
// Counts the input rows of a tile and, after the fourth, issues the six
// output rows into the datapath pipeline one per advancing cycle.
// ---------------------------------------------------------------------------
`include "winograd_f4x3_tile_transform_assert.svh"

module wft_ctrl
	import wft_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output wft_cmd_t  cmd,
	input  wft_stat_t stat
);

	typedef enum logic {
		ST_LOAD,
		ST_ISSUE
	} state_t;

	state_t            state_q;
	logic [ROW_W-1:0]  row_cnt_q;
	logic [OROW_W-1:0] iss_q;
	logic              in_acc;

	// Input rows are taken only while loading; the store is busy while issuing.
	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;

	// Commands to the datapath.
	always_comb begin
		cmd.wr_en     = in_acc;
		cmd.wr_row    = row_cnt_q;
		cmd.issue     = (state_q == ST_ISSUE);
		cmd.issue_row = iss_q;
	end

	// State, row counter and issue counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			row_cnt_q <= '0;
			iss_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (row_cnt_q == LAST_IN_ROW) begin
							state_q   <= ST_ISSUE;
							row_cnt_q <= '0;
							iss_q     <= '0;
						end else begin
							row_cnt_q <= row_cnt_q + 2'd1;
						end
					end
				end
				ST_ISSUE: begin
					if (stat.adv) begin
						if (iss_q == LAST_OUT_ROW) begin
							state_q <= ST_LOAD;
							iss_q   <= '0;
						end else begin
							iss_q <= iss_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// The fourth row of a tile starts issue from the first output row.
	`WFT_ASSERT(a_ctrl_start, (in_acc && row_cnt_q == LAST_IN_ROW) |=> (state_q == ST_ISSUE && iss_q == 3'd0), "issue did not start after the fourth row")
	// Issuing the last output row frees the store for a new tile.
	`WFT_ASSERT(a_ctrl_end, (state_q == ST_ISSUE && stat.adv && iss_q == LAST_OUT_ROW) |=> (state_q == ST_LOAD && row_cnt_q == 2'd0), "issue did not end after the sixth row")
	// The row counter does not move while rows are being issued.
	`WFT_NEVER(a_ctrl_cnt, state_q == ST_ISSUE && row_cnt_q != 2'd0, "row counter busy during issue")

endmodule

// ===== design/wft_dp.sv =====
// ---------------------------------------------------------------------------
// Winograd tile transform datapath
// Holds the configuration registers and the masked 4x4 tile, and runs each
// issued output row through a four-stage pipeline: column pass, row pass,
// reciprocal multiply, and bias removal with saturation into the output register.
// ---------------------------------------------------------------------------
`include "winograd_f4x3_tile_transform_assert.svh"

module wft_dp
	import wft_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  wft_cmd_t                    cmd,
	output wft_stat_t                   stat,
	input  logic                        cfg_valid,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [REG_W-1:0]            cfg_data,
	input  logic [TILE_W-1:0]           tile_col,
	input  logic [TILE_W-1:0]           tile_row,
	input  logic signed [SAMPLE_W-1:0]  sample_0,
	input  logic signed [SAMPLE_W-1:0]  sample_1,
	input  logic signed [SAMPLE_W-1:0]  sample_2,
	input  logic signed [SAMPLE_W-1:0]  sample_3,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [OROW_W-1:0]           out_row,
	output logic signed [RES_W-1:0]     col_0,
	output logic signed [RES_W-1:0]     col_1,
	output logic signed [RES_W-1:0]     col_2,
	output logic signed [RES_W-1:0]     col_3,
	output logic signed [RES_W-1:0]     col_4,
	output logic signed [RES_W-1:0]     col_5,
	output logic                        last
);

	logic [REG_W-1:0]           height_q;
	logic [REG_W-1:0]           width_q;
	logic signed [SAMPLE_W-1:0] samp [COLS];
	logic signed [SAMPLE_W-1:0] masked [COLS];
	logic signed [SAMPLE_W-1:0] x_q [ROWS][COLS];
	logic                       adv;

	logic                       v_s1, v_s2, v_s3, out_valid_q;
	logic [OROW_W-1:0]          row_s1, row_s2, row_s3, out_row_q;
	logic                       last_q;
	logic signed [T_W-1:0]      t_next [COLS];
	logic signed [T_W-1:0]      t_s1 [COLS];
	logic signed [P_W-1:0]      p_next [ORES];
	logic signed [P_W-1:0]      p_s2 [ORES];
	logic [Q_W-1:0]             q_next [ORES];
	logic [Q_W-1:0]             q_s3 [ORES];
	logic signed [RES_W-1:0]    r_next [ORES];
	logic signed [RES_W-1:0]    col_q [ORES];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= REG_RESET;
			width_q  <= REG_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_OUT_HEIGHT: height_q <= cfg_data;
				CFG_OUT_WIDTH:  width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero samples that lie outside the valid part of the plane.
	assign samp[0] = sample_0;
	assign samp[1] = sample_1;
	assign samp[2] = sample_2;
	assign samp[3] = sample_3;

	always_comb begin
		logic [DIM_BITS-1:0] ypos;
		logic [DIM_BITS-1:0] xpos;
		ypos = {tile_row, cmd.wr_row};
		for (int c = 0; c < COLS; c++) begin
			xpos = {tile_col, ROW_W'(c)};
			if ({1'b0, ypos} >= height_q || {1'b0, xpos} >= width_q) begin
				masked[c] = '0;
			end else begin
				masked[c] = samp[c];
			end
		end
	end

	// Tile store: rows 0 to 2 held for the tile, row 3 written with them.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			for (int c = 0; c < COLS; c++) begin
				x_q[cmd.wr_row][c] <= masked[c];
			end
		end
	end

	// The whole pipeline moves unless the output register holds a stalled result.
	assign adv      = !out_valid_q || !out_stall;
	assign stat.adv = adv;

	// Column pass for the issued row: t = M[i] applied down each column.
	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			t_next[c] = T_W'(wft_lin(cmd.issue_row,
				ACC_W'(x_q[0][c]), ACC_W'(x_q[1][c]),
				ACC_W'(x_q[2][c]), ACC_W'(x_q[3][c])));
		end
	end

	// Row pass: P[s] = M[s] applied across the row of t.
	always_comb begin
		for (int s = 0; s < ORES; s++) begin
			p_next[s] = P_W'(wft_lin(OROW_W'(s),
				ACC_W'(t_s1[0]), ACC_W'(t_s1[1]),
				ACC_W'(t_s1[2]), ACC_W'(t_s1[3])));
		end
	end

	// Biased dividend times the reciprocal of nine; the high bits are the quotient.
	always_comb begin
		logic signed [U_W:0]  nb;
		logic [PROD_W-1:0]    prod;
		for (int s = 0; s < ORES; s++) begin
			nb = ((U_W + 1)'(p_s2[s]) <<< 2) + (U_W + 1)'(RND_OFS)
				+ $signed({1'b0, DIV_BIAS});
			prod = PROD_W'(nb[U_W-1:0]) * PROD_W'(RECIP);
			q_next[s] = prod[PROD_W-1 -: Q_W];
		end
	end

	// Remove the bias and saturate to the result width.
	always_comb begin
		logic signed [Q_W:0] r;
		for (int s = 0; s < ORES; s++) begin
			r = $signed({1'b0, q_s3[s]}) - (Q_W + 1)'(2 ** BIAS_EXP);
			if (r > (Q_W + 1)'(RES_MAX)) begin
				r_next[s] = RES_W'(RES_MAX);
			end else if (r < (Q_W + 1)'(RES_MIN)) begin
				r_next[s] = RES_W'(RES_MIN);
			end else begin
				r_next[s] = RES_W'(r);
			end
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1    <= cmd.issue_row;
			row_s2    <= row_s1;
			row_s3    <= row_s2;
			out_row_q <= row_s3;
			last_q    <= (row_s3 == LAST_OUT_ROW);
			t_s1      <= t_next;
			p_s2      <= p_next;
			q_s3      <= q_next;
			col_q     <= r_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign last      = last_q;
	assign col_0     = col_q[0];
	assign col_1     = col_q[1];
	assign col_2     = col_q[2];
	assign col_3     = col_q[3];
	assign col_4     = col_q[4];
	assign col_5     = col_q[5];

	// The tile store is never written while its rows are being issued.
	`WFT_NEVER(a_dp_overlap, cmd.issue && cmd.wr_en, "tile store written during issue")
	// Within a tile the rows leave in order behind one another.
	`WFT_ASSERT(a_dp_order, (out_valid_q && !out_stall && !last_q && v_s3) |=> (out_valid_q && out_row_q == OROW_W'($past(out_row_q) + 3'd1)), "output rows out of order")
	// The last flag marks exactly the final row of a tile.
	`WFT_ASSERT(a_dp_last, out_valid_q |-> (last_q == (out_row_q == LAST_OUT_ROW)), "last flag does not match row")

endmodule

// ===== design/winograd_f4x3_tile_transform.sv =====
// Input rows are taken only while the controller loads; after the fourth row of
// a tile is taken, its six output rows are issued one per advancing cycle through
// the column pass, row pass, reciprocal multiply and output registers in turn.
// No input row is taken until the last output row of the tile has been issued.
// Reset: arst_n clears the controller and pipeline valid bits and sets both
// configuration registers to 4096; the tile store is written before it is read.
// ---------------------------------------------------------------------------
// Winograd F(4x4,3x3) gradient tile transform
// Takes a 4x4 tile one row per transaction, masks samples outside the plane,
// and emits the 6x6 transformed tile one row per transaction.
// ---------------------------------------------------------------------------
module winograd_f4x3_tile_transform
	import wft_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [REG_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [TILE_W-1:0]           tile_col,
	input  logic [TILE_W-1:0]           tile_row,
	input  logic signed [SAMPLE_W-1:0]  sample_0,
	input  logic signed [SAMPLE_W-1:0]  sample_1,
	input  logic signed [SAMPLE_W-1:0]  sample_2,
	input  logic signed [SAMPLE_W-1:0]  sample_3,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [OROW_W-1:0]           out_row,
	output logic signed [RES_W-1:0]     col_0,
	output logic signed [RES_W-1:0]     col_1,
	output logic signed [RES_W-1:0]     col_2,
	output logic signed [RES_W-1:0]     col_3,
	output logic signed [RES_W-1:0]     col_4,
	output logic signed [RES_W-1:0]     col_5,
	output logic                        last
);

	wft_cmd_t  cmd;
	wft_stat_t stat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	wft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

	wft_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tile_col  (tile_col),
		.tile_row  (tile_row),
		.sample_0  (sample_0),
		.sample_1  (sample_1),
		.sample_2  (sample_2),
		.sample_3  (sample_3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.col_0     (col_0),
		.col_1     (col_1),
		.col_2     (col_2),
		.col_3     (col_3),
		.col_4     (col_4),
		.col_5     (col_5),
		.last      (last)
	);

endmodule

// ===== bench/tb_winograd_f4x3_tile_transform.sv =====
// ---------------------------------------------------------------------------
// Testbench for the Winograd F(4x4,3x3) gradient tile transform
// Sends gradient tiles one row per transaction under several plane sizes and
// checks every emitted 6x6 row against a bit-exact fixed-point predictor.
// Both handshakes idle and stall at random, and one long output stall fills
// the block.
// ---------------------------------------------------------------------------
module tb_winograd_f4x3_tile_transform;
	import wft_pkg::*;

	localparam int PHASES = 8;
	localparam int TILES_PER_PHASE = 10;
	localparam int SETTLE_CYCLES = 16;
	localparam int LONG_HOLD = 150;
	localparam int HOLD_AFTER = 30;
	localparam int QUIET_LIMIT = 4000;

	// Integer matrix M of the output transform (A = M / 24).
	localparam int WINO_M [ORES][COLS] = '{
		'{ 6,  0,  0,  0},
		'{-4, -4, -4, -4},
		'{-4,  4, -4,  4},
		'{ 1,  2,  4,  8},
		'{ 1, -2,  4, -8},
		'{ 0,  0,  0, 24}
	};

	typedef struct packed {
		logic [TILE_W-1:0]                tcol;
		logic [TILE_W-1:0]                trow;
		logic [COLS-1:0][SAMPLE_W-1:0]    smp;
	} grad_row_t;

	typedef struct packed {
		logic [OROW_W-1:0]                orow;
		logic [ORES-1:0][RES_W-1:0]       col;
		logic                             last;
	} wino_row_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = CFG_OUT_HEIGHT;
	logic [REG_W-1:0]           cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [TILE_W-1:0]          tile_col = '0;
	logic [TILE_W-1:0]          tile_row = '0;
	logic signed [SAMPLE_W-1:0] sample_0 = '0;
	logic signed [SAMPLE_W-1:0] sample_1 = '0;
	logic signed [SAMPLE_W-1:0] sample_2 = '0;
	logic signed [SAMPLE_W-1:0] sample_3 = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [OROW_W-1:0]          out_row;
	logic signed [RES_W-1:0]    col_0, col_1, col_2, col_3, col_4, col_5;
	logic                       last;

	winograd_f4x3_tile_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.tile_col  (tile_col),
		.tile_row  (tile_row),
		.sample_0  (sample_0),
		.sample_1  (sample_1),
		.sample_2  (sample_2),
		.sample_3  (sample_3),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_row   (out_row),
		.col_0     (col_0),
		.col_1     (col_1),
		.col_2     (col_2),
		.col_3     (col_3),
		.col_4     (col_4),
		.col_5     (col_5),
		.last      (last)
	);

	// Input rows waiting to be sent and output rows still owed by the block.
	grad_row_t pending_rows [$];
	wino_row_t owed_rows [$];

	// Predictor state: plane size, stored rows of the current tile, row index.
	int unsigned plane_height = REG_RESET;
	int unsigned plane_width = REG_RESET;
	longint      held_rows [3][COLS];
	int          row_idx = 0;

	int          errors = 0;
	int          rows_taken = 0;
	bit          calm = 1'b0;
	grad_row_t   drv_row;
	int          gap_left = 0;
	int          stall_left = 0;
	bit          hold_done = 1'b0;
	int          quiet = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Idle length: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Tile index: anywhere in range, or on the edge of the configured size.
	function automatic logic [TILE_W-1:0] pick_tile(input int unsigned lim);
		int base;
		if ($urandom_range(0, 2) == 0)
			return TILE_W'($urandom_range(0, 1023));
		base = int'(lim / 4) + $urandom_range(0, 2) - 1;
		if (base < 0)
			base = 0;
		if (base > 1023)
			base = 1023;
		return TILE_W'(base);
	endfunction

	// Mask one input row; on the fourth row compute Y = M X M^T scaled to Q16.8.
	task automatic transform_tile_row(input grad_row_t it);
		int unsigned ypos, xpos;
		longint      cur [COLS];
		longint      xv [ROWS][COLS];
		longint      tv [ORES][COLS];
		longint      acc, num, q;
		wino_row_t   res;
		int          i, s, c, k;
		ypos = int'(it.trow) * 4 + row_idx;
		for (c = 0; c < COLS; c++) begin
			xpos = int'(it.tcol) * 4 + c;
			if (ypos >= plane_height || xpos >= plane_width)
				cur[c] = 0;
			else
				cur[c] = longint'($signed(it.smp[c]));
		end
		if (row_idx < 3) begin
			for (c = 0; c < COLS; c++)
				held_rows[row_idx][c] = cur[c];
			row_idx++;
			return;
		end
		for (k = 0; k < 3; k++)
			for (c = 0; c < COLS; c++)
				xv[k][c] = held_rows[k][c];
		for (c = 0; c < COLS; c++)
			xv[3][c] = cur[c];
		for (i = 0; i < ORES; i++)
			for (c = 0; c < COLS; c++) begin
				acc = 0;
				for (k = 0; k < ROWS; k++)
					acc += WINO_M[i][k] * xv[k][c];
				tv[i][c] = acc;
			end
		for (i = 0; i < ORES; i++) begin
			res.orow = OROW_W'(i);
			res.last = (OROW_W'(i) == LAST_OUT_ROW);
			for (s = 0; s < ORES; s++) begin
				acc = 0;
				for (c = 0; c < COLS; c++)
					acc += tv[i][c] * WINO_M[s][c];
				// Round 4P/9 to nearest with a floor division.
				num = 8 * acc + 9;
				if (num >= 0)
					q = num / 18;
				else
					q = -((-num + 17) / 18);
				if (q > RES_MAX)
					q = RES_MAX;
				if (q < RES_MIN)
					q = RES_MIN;
				res.col[s] = RES_W'(q);
			end
			owed_rows.push_back(res);
		end
		row_idx = 0;
	endtask

	// Configuration write: hold the transaction until the block takes it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= REG_W'(val);
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_OUT_HEIGHT)
			plane_height = val & ((1 << REG_W) - 1);
		else
			plane_width = val & ((1 << REG_W) - 1);
		cfg_valid <= 1'b0;
	endtask

	// Wait until the sender is empty and nothing is owed, then let the pipe settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_rows.size() != 0 || in_valid || owed_rows.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Input driver: predict on each accepted transaction, then offer the next row.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				transform_tile_row(drv_row);
				rows_taken <= rows_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_rows.size() != 0) begin
					drv_row = pending_rows.pop_front();
					tile_col <= drv_row.tcol;
					tile_row <= drv_row.trow;
					sample_0 <= drv_row.smp[0];
					sample_1 <= drv_row.smp[1];
					sample_2 <= drv_row.smp[2];
					sample_3 <= drv_row.smp[3];
					in_valid <= 1'b1;
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output stall: random stretches, plus one long hold while rows keep coming.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!hold_done && rows_taken >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			out_stall <= 1'b1;
			stall_left <= LONG_HOLD;
		end else if (!calm && $urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Output monitor: compare each accepted row with the oldest owed row.
	always @(posedge clk) begin : monitor
		wino_row_t                  want;
		logic [ORES-1:0][RES_W-1:0] got;
		int                         s;
		if (arst_n && out_valid && !out_stall) begin
			got = {col_5, col_4, col_3, col_2, col_1, col_0};
			if (owed_rows.size() == 0) begin
				$display("%0t: unexpected result, out_row %0d", $time, out_row);
				errors++;
			end else begin
				want = owed_rows.pop_front();
				if (out_row !== want.orow) begin
					$display("%0t: out_row expected %0d actual %0d", $time, want.orow, out_row);
					errors++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0d actual %0d", $time, want.last, last);
					errors++;
				end
				for (s = 0; s < ORES; s++)
					if (got[s] !== want.col[s]) begin
						$display("%0t: row %0d col_%0d expected %0d actual %0d", $time,
							want.orow, s, $signed(want.col[s]), $signed(got[s]));
						errors++;
					end
			end
		end
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet == QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus: directed tiles at the reset size, then random phases per size.
	initial begin
		grad_row_t   it;
		int unsigned hgt, wid;
		int          d, r, c, ph, t;
		bit          own_coords;

		for (d = 0; d < 6; d++) begin
			for (r = 0; r < ROWS; r++) begin
				case (d)
					0: begin
						it.tcol = '0;
						it.trow = '0;
					end
					1: begin
						it.tcol = '1;
						it.trow = '1;
					end
					// Each row of this tile carries its own coordinates.
					3: begin
						it.tcol = TILE_W'(r * 300);
						it.trow = TILE_W'(1023 - r * 200);
					end
					default: begin
						it.tcol = TILE_W'($urandom_range(0, 1023));
						it.trow = TILE_W'($urandom_range(0, 1023));
					end
				endcase
				for (c = 0; c < COLS; c++)
					case (d)
						0: it.smp[c] = 16'sh7fff;
						1: it.smp[c] = 16'sh8000;
						2: it.smp[c] = ((r + c) % 2 != 0) ? 16'sh7fff : 16'sh8000;
						3: it.smp[c] = (c == 0) ? 16'sh0000 : (c == 1) ? 16'sh0001 :
							(c == 2) ? 16'shffff : 16'sh8000;
						4: it.smp[c] = SAMPLE_W'((r * 4 + c) * 2000 - 16000);
						default: it.smp[c] = SAMPLE_W'($urandom);
					endcase
				pending_rows.push_back(it);
			end
		end

		// Hold reset, then release it.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					hgt = 8191;
					wid = 8191;
				end
				// A zero size masks the whole plane.
				1: begin
					hgt = 0;
					wid = $urandom_range(1, 4096);
				end
				2: begin
					hgt = $urandom_range(1, 4096);
					wid = 0;
				end
				3: begin
					hgt = 1;
					wid = 1;
				end
				4: begin
					hgt = 4096;
					wid = 4096;
				end
				7: begin
					hgt = $urandom_range(0, 8191);
					wid = $urandom_range(0, 8191);
				end
				default: begin
					hgt = $urandom_range(1, 4096);
					wid = $urandom_range(1, 4096);
				end
			endcase
			write_reg(CFG_OUT_HEIGHT, hgt);
			write_reg(CFG_OUT_WIDTH, wid);
			@(negedge clk);
			calm = (ph == 4);
			for (t = 0; t < TILES_PER_PHASE; t++) begin
				own_coords = ($urandom_range(0, 3) == 0);
				it.tcol = pick_tile(wid);
				it.trow = pick_tile(hgt);
				for (r = 0; r < ROWS; r++) begin
					if (own_coords) begin
						it.tcol = pick_tile(wid);
						it.trow = pick_tile(hgt);
					end
					for (c = 0; c < COLS; c++)
						it.smp[c] = SAMPLE_W'($urandom);
					pending_rows.push_back(it);
				end
			end
		end

		wait_drained();
		if (errors == 0 && owed_rows.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
